/* rtl/core/simplex_basis_gradient_assert.svh */
// ---------------------------------------------------------------------------
// Simplex basis gradient assertion macros
// Property macros used by the block's top-level file to check itself.
// ---------------------------------------------------------------------------
`ifndef SIMPLEX_BASIS_GRADIENT_ASSERT_SVH
`define SIMPLEX_BASIS_GRADIENT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define SBG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define SBG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sbg_pkg.sv */
// ---------------------------------------------------------------------------
// Simplex basis gradient package
// Widths, codes, types and register defaults shared across the block.
// ---------------------------------------------------------------------------
package sbg_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int GRAD_WIDTH  = 48;
    localparam int COORD_FRAC  = 20;
    localparam int GRAD_FRAC   = 24;
    localparam int QSHIFT      = COORD_FRAC + GRAD_FRAC;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int CR_W   = PROD_W + 1;
    localparam int LO_W   = DIFF_W + 1;
    localparam int PLO_W  = LO_W + 1 + DIFF_W;
    localparam int PHI_W  = (CR_W - LO_W) + DIFF_W;
    localparam int DEN_W  = CR_W + DIFF_W + 2;
    localparam int NB_W   = CR_W + 1;
    localparam int QB     = GRAD_WIDTH + 1;
    localparam int NUM_W  = NB_W + QSHIFT;
    localparam int MAG_W  = QB + 1;
    localparam int GEO_ST = 7;

    localparam int IN_W   = 12 * COORD_WIDTH;
    localparam int OUT_W  = 3 * GRAD_WIDTH;

    localparam logic [1:0] DIM_2D          = 2'd2;
    localparam logic       CFG_DIMENSION   = 1'b0;
    localparam logic       CFG_SMALL_FLOOR = 1'b1;
    localparam logic [1:0] DIM_RESET       = 2'd3;
    localparam logic [7:0] FLOOR_RESET     = 8'd2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [CR_W-1:0]        cr_t;
    typedef logic signed [PLO_W-1:0]       plo_t;
    typedef logic signed [PHI_W-1:0]       phi_t;
    typedef logic signed [DEN_W-1:0]       den_t;
    typedef logic signed [NB_W-1:0]        nb_t;
    typedef logic signed [GRAD_WIDTH-1:0]  grad_t;

    typedef struct packed {
        logic [1:0] corner;
        logic       last;
        logic       degen;
    } tag_t;

    typedef struct packed {
        logic [NB_W-1:0] nmag;
        logic            neg;
    } lane_in_t;

    typedef struct packed {
        logic [DEN_W-1:0] r;
        logic [QB-1:0]    q;
        logic [QB-1:0]    nlow;
        logic             neg;
        logic             over;
    } div_st_t;

endpackage

/* rtl/core/sbg_seq.sv */
// ---------------------------------------------------------------------------
// Simplex basis gradient corner sequencer
// Holds one element and issues its corners, one per cycle unless stalled, in rotated order.
// ---------------------------------------------------------------------------
module sbg_seq
    import sbg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   two_d,
    input  logic   s_valid,
    input  coord_t in_v [4][3],
    output logic   s_ready,
    output logic   out_valid,
    output tag_t   out_tag,
    output coord_t out_p [4][3]
);

    logic       hold_valid_reg;
    logic [1:0] k_reg;
    coord_t     hold_v_reg [4][3];
    logic       out_valid_reg;
    tag_t       tag_reg;
    coord_t     p_reg [4][3];
    logic [1:0] k_last;
    logic       issue;
    logic       last_issue;
    logic       accept;

    function automatic logic [1:0] rot_idx(logic [1:0] k, logic [1:0] j, logic tw);
        logic [2:0] sum;
        sum = {1'b0, k} + {1'b0, j};
        if (tw && sum >= 3'd3)
        begin
            sum = sum - 3'd3;
        end
        else if (!tw && sum >= 3'd4)
        begin
            sum = sum - 3'd4;
        end
        return sum[1:0];
    endfunction

    assign k_last     = two_d ? 2'd2 : 2'd3;
    assign issue      = hold_valid_reg && en;
    assign last_issue = issue && (k_reg == k_last);
    assign s_ready    = !hold_valid_reg || last_issue;
    assign accept     = s_valid && s_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            k_reg          <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                hold_valid_reg <= 1'b1;
                k_reg          <= 2'd0;
            end
            else if (last_issue)
            begin
                hold_valid_reg <= 1'b0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + 2'd1;
            end
            if (en)
            begin
                out_valid_reg <= hold_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_v_reg <= in_v;
        end
        if (en)
        begin
            tag_reg.corner <= k_reg;
            tag_reg.last   <= (k_reg == k_last);
            tag_reg.degen  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p_reg[i][j] <= hold_v_reg[rot_idx(k_reg, 2'(i), two_d)][j];
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = tag_reg;
    assign out_p     = p_reg;

endmodule

/* rtl/core/sbg_geom.sv */
// ---------------------------------------------------------------------------
// Simplex basis gradient geometry pipeline
// Edge vectors, face cross products, denominator and numerators in 7 stages.
// ---------------------------------------------------------------------------
module sbg_geom
    import sbg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             two_d,
    input  logic             in_valid,
    input  tag_t             in_tag,
    input  coord_t           in_p [4][3],
    output logic             out_valid,
    output tag_t             out_tag,
    output logic [DEN_W-1:0] out_dmag,
    output lane_in_t         out_lane [3]
);

    logic [GEO_ST-1:0] vld_reg;
    tag_t              tag_reg [GEO_ST];

    diff_t a_reg [3], b_reg [3], c_reg [3], e2_reg, f2_reg;
    diff_t a2_reg [3], b2_reg [3], a3_reg [3], b3_reg [3];
    diff_t opx [6], opy [6];
    prod_t m_reg [6];
    cr_t   cr_reg [3];
    plo_t  plo_reg [3];
    phi_t  phi_reg [3];
    nb_t   nb4_reg [3], nb5_reg [3], nb6_reg [3];
    cr_t   cr0_4_reg, cr0_5_reg;
    den_t  s_reg [3];
    den_t  den_reg;
    logic  degen_reg;
    logic [DEN_W-1:0] dmag_reg;
    lane_in_t         lane_reg [3];
    nb_t   nb_next [3];

    always_comb
    begin
        opx[0] = two_d ? a_reg[0] : b_reg[1];
        opy[0] = two_d ? f2_reg   : c_reg[2];
        opx[1] = two_d ? a_reg[1] : b_reg[2];
        opy[1] = two_d ? e2_reg   : c_reg[1];
        opx[2] = b_reg[2];
        opy[2] = c_reg[0];
        opx[3] = b_reg[0];
        opy[3] = c_reg[2];
        opx[4] = b_reg[0];
        opy[4] = c_reg[1];
        opx[5] = b_reg[1];
        opy[5] = c_reg[0];
        for (int j = 0; j < 3; j++)
        begin
            nb_next[j] = -nb_t'(cr_reg[j]);
        end
        if (two_d)
        begin
            nb_next[0] = -nb_t'(b3_reg[1]);
            nb_next[1] = nb_t'(b3_reg[0]);
            nb_next[2] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[GEO_ST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
            for (int s = 1; s < GEO_ST; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
            for (int j = 0; j < 3; j++)
            begin
                a_reg[j] <= diff_t'(in_p[1][j]) - diff_t'(in_p[0][j]);
                b_reg[j] <= diff_t'(in_p[2][j]) - diff_t'(in_p[1][j]);
                c_reg[j] <= diff_t'(in_p[3][j]) - diff_t'(in_p[1][j]);
            end
            e2_reg <= diff_t'(in_p[2][0]) - diff_t'(in_p[0][0]);
            f2_reg <= diff_t'(in_p[2][1]) - diff_t'(in_p[0][1]);

            for (int i = 0; i < 6; i++)
            begin
                m_reg[i] <= prod_t'(opx[i]) * prod_t'(opy[i]);
            end
            a2_reg <= a_reg;
            b2_reg <= b_reg;

            for (int j = 0; j < 3; j++)
            begin
                cr_reg[j] <= cr_t'(m_reg[2*j]) - cr_t'(m_reg[2*j+1]);
            end
            a3_reg <= a2_reg;
            b3_reg <= b2_reg;

            for (int j = 0; j < 3; j++)
            begin
                plo_reg[j] <= plo_t'($signed({1'b0, cr_reg[j][LO_W-1:0]})) * plo_t'(a3_reg[j]);
                phi_reg[j] <= phi_t'($signed(cr_reg[j][CR_W-1:LO_W])) * phi_t'(a3_reg[j]);
            end
            nb4_reg   <= nb_next;
            cr0_4_reg <= cr_reg[0];

            for (int j = 0; j < 3; j++)
            begin
                s_reg[j] <= (den_t'(phi_reg[j]) <<< LO_W) + den_t'(plo_reg[j]);
            end
            nb5_reg   <= nb4_reg;
            cr0_5_reg <= cr0_4_reg;

            den_reg <= two_d ? den_t'(cr0_5_reg) : (s_reg[0] + s_reg[1] + s_reg[2]);
            nb6_reg <= nb5_reg;

            degen_reg <= (den_reg == '0);
            dmag_reg  <= den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);
            for (int j = 0; j < 3; j++)
            begin
                lane_reg[j].nmag <= nb6_reg[j][NB_W-1] ? NB_W'(-nb6_reg[j])
                                                       : NB_W'(nb6_reg[j]);
                lane_reg[j].neg  <= nb6_reg[j][NB_W-1] ^ den_reg[DEN_W-1];
            end
        end
    end

    always_comb
    begin
        out_tag       = tag_reg[GEO_ST-1];
        out_tag.degen = degen_reg;
    end

    assign out_valid = vld_reg[GEO_ST-1];
    assign out_dmag  = dmag_reg;
    assign out_lane  = lane_reg;

endmodule

/* rtl/core/sbg_div.sv */
// ---------------------------------------------------------------------------
// Simplex basis gradient divider pipeline
// Restoring division, one quotient bit per stage, three lanes sharing a divisor.
// ---------------------------------------------------------------------------
module sbg_div
    import sbg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  tag_t             in_tag,
    input  logic [DEN_W-1:0] in_dmag,
    input  lane_in_t         in_lane [3],
    output logic             out_valid,
    output tag_t             out_tag,
    output logic [DEN_W-1:0] out_dmag,
    output div_st_t          out_st [3]
);

    logic [QB:0]      vld_reg;
    tag_t             tag_reg [QB+1];
    logic [DEN_W-1:0] d_reg [QB+1];
    div_st_t          st_reg [QB+1][3];
    div_st_t          st_next [QB+1][3];
    logic [NUM_W-1:0] num [3];
    logic [DEN_W:0]   trial [QB+1][3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            num[l]              = {in_lane[l].nmag, {QSHIFT{1'b0}}};
            st_next[0][l].neg   = in_lane[l].neg;
            st_next[0][l].q     = '0;
            st_next[0][l].nlow  = num[l][QB-1:0];
            st_next[0][l].over  = DEN_W'(num[l][NUM_W-1:QB]) >= in_dmag;
            st_next[0][l].r     = st_next[0][l].over ? '0 : DEN_W'(num[l][NUM_W-1:QB]);
            trial[0][l]         = '0;
        end
        for (int s = 1; s <= QB; s++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                st_next[s][l] = st_reg[s-1][l];
                trial[s][l]   = {st_reg[s-1][l].r, st_reg[s-1][l].nlow[QB-s]};
                if (trial[s][l] >= {1'b0, d_reg[s-1]})
                begin
                    st_next[s][l].r       = DEN_W'(trial[s][l] - {1'b0, d_reg[s-1]});
                    st_next[s][l].q[QB-s] = 1'b1;
                end
                else
                begin
                    st_next[s][l].r = DEN_W'(trial[s][l]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QB-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
            d_reg[0]   <= in_dmag;
            for (int s = 1; s <= QB; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
                d_reg[s]   <= d_reg[s-1];
            end
            for (int s = 0; s <= QB; s++)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign out_tag   = tag_reg[QB];
    assign out_dmag  = d_reg[QB];
    assign out_st    = st_reg[QB];

endmodule

/* rtl/core/sbg_fin.sv */
// ---------------------------------------------------------------------------
// Simplex basis gradient finishing stage
// Rounds quotients, saturates, floors, restores sign; zeroes degenerate and 2D z.
// ---------------------------------------------------------------------------
module sbg_fin
    import sbg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             two_d,
    input  logic [7:0]       small_floor,
    input  logic             in_valid,
    input  tag_t             in_tag,
    input  logic [DEN_W-1:0] in_dmag,
    input  div_st_t          in_st [3],
    output logic             out_valid,
    output tag_t             out_tag,
    output grad_t            out_grad [3]
);

    logic             vld_reg;
    tag_t             tag_reg;
    logic [MAG_W-1:0] mag_reg [3];
    logic             neg_reg [3];
    logic             over_reg [3];
    logic [MAG_W-1:0] lim [3];
    logic [MAG_W-1:0] sat [3];
    logic             sgn [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg <= in_tag;
            for (int l = 0; l < 3; l++)
            begin
                mag_reg[l]  <= MAG_W'(in_st[l].q)
                             + MAG_W'({in_st[l].r, 1'b0} >= {1'b0, in_dmag});
                neg_reg[l]  <= in_st[l].neg;
                over_reg[l] <= in_st[l].over;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            lim[l] = (MAG_W'(1) << (GRAD_WIDTH - 1)) - MAG_W'(!neg_reg[l]);
            sat[l] = (over_reg[l] || mag_reg[l] > lim[l]) ? lim[l] : mag_reg[l];
            sgn[l] = neg_reg[l];
            if (sat[l] < MAG_W'(small_floor))
            begin
                sat[l] = MAG_W'(small_floor);
                sgn[l] = 1'b0;
            end
            out_grad[l] = sgn[l] ? grad_t'(-sat[l]) : grad_t'(sat[l]);
            if (tag_reg.degen || (two_d && l == 2))
            begin
                out_grad[l] = '0;
            end
        end
    end

    assign out_valid = vld_reg;
    assign out_tag   = tag_reg;

endmodule

/* rtl/core/simplex_basis_gradient.sv */
// ---------------------------------------------------------------------------
// Simplex basis gradient
// Hat-function gradients of every corner of a triangle or tetrahedron.
// ---------------------------------------------------------------------------
// Channel   Direction  Beat
// s_*       in         one element: 12 vertex coordinates
// m_*       out        one corner: gradient, corner, degenerate flag
// cfg_*     in         one register write: index and data
//
// An element of n corners (3 for triangles, 4 for tetrahedra) is taken as the
// sequencer issues the last corner of the one before; the sequencer issues one
// corner per cycle unless the output stalls. Each corner result passes the
// geometry, divider, finishing and output registers in order, one corner a cycle.
// Reset restores dimension 3 and floor 2 and empties every stage.
// A stalled output freezes all stages together; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "simplex_basis_gradient_assert.svh"

module simplex_basis_gradient
    import sbg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // grad_x, grad_y, grad_z
    output logic [OUT_W-1:0] m_tdata,
    // corner, degenerate
    output logic [2:0]       m_tuser,
    output logic             m_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [7:0]       cfg_data
);

    logic [1:0]       dim_reg;
    logic [7:0]       floor_reg;
    logic             two_d;
    logic             en;
    coord_t           in_v [4][3];

    logic             seq_valid;
    tag_t             seq_tag;
    coord_t           seq_p [4][3];
    logic             geo_valid;
    tag_t             geo_tag;
    logic [DEN_W-1:0] geo_dmag;
    lane_in_t         geo_lane [3];
    logic             div_valid;
    tag_t             div_tag;
    logic [DEN_W-1:0] div_dmag;
    div_st_t          div_st [3];
    logic             fin_valid;
    tag_t             fin_tag;
    grad_t            fin_grad [3];

    logic             out_valid_reg;
    tag_t             out_tag_reg;
    grad_t            out_grad_reg [3];

    assign cfg_ready = 1'b1;
    assign two_d     = (dim_reg == DIM_2D);
    assign en        = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg   <= DIM_RESET;
            floor_reg <= FLOOR_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DIMENSION:   dim_reg   <= cfg_data[1:0];
                CFG_SMALL_FLOOR: floor_reg <= cfg_data;
                default:         dim_reg   <= dim_reg;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                in_v[i][j] = s_tdata[(i*3+j)*COORD_WIDTH +: COORD_WIDTH];
            end
        end
    end

    sbg_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .two_d     (two_d),
        .s_valid   (s_tvalid),
        .in_v      (in_v),
        .s_ready   (s_tready),
        .out_valid (seq_valid),
        .out_tag   (seq_tag),
        .out_p     (seq_p)
    );

    sbg_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .two_d     (two_d),
        .in_valid  (seq_valid),
        .in_tag    (seq_tag),
        .in_p      (seq_p),
        .out_valid (geo_valid),
        .out_tag   (geo_tag),
        .out_dmag  (geo_dmag),
        .out_lane  (geo_lane)
    );

    sbg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (geo_valid),
        .in_tag    (geo_tag),
        .in_dmag   (geo_dmag),
        .in_lane   (geo_lane),
        .out_valid (div_valid),
        .out_tag   (div_tag),
        .out_dmag  (div_dmag),
        .out_st    (div_st)
    );

    sbg_fin u_fin (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .two_d       (two_d),
        .small_floor (floor_reg),
        .in_valid    (div_valid),
        .in_tag      (div_tag),
        .in_dmag     (div_dmag),
        .in_st       (div_st),
        .out_valid   (fin_valid),
        .out_tag     (fin_tag),
        .out_grad    (fin_grad)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_tag_reg  <= fin_tag;
            out_grad_reg <= fin_grad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_grad_reg[2], out_grad_reg[1], out_grad_reg[0]};
    assign m_tuser  = {out_tag_reg.degen, out_tag_reg.corner};
    assign m_tlast  = out_tag_reg.last;

    `SBG_ASSERT_IMPLY(a_last_corner, m_tvalid && m_tlast,
        m_tuser[1:0] == (two_d ? 2'd2 : 2'd3), "last beat on wrong corner")
    `SBG_ASSERT_IMPLY(a_degen_zero, m_tvalid && m_tuser[2],
        m_tdata == '0, "degenerate element with nonzero gradient")
    `SBG_ASSERT_IMPLY(a_2d_no_z, m_tvalid && two_d,
        m_tdata[OUT_W-1:2*GRAD_WIDTH] == '0, "nonzero z gradient in 2D")
    `SBG_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready,
        !s_tready, "element accepted while corners still pending")

endmodule
